### rtl/crsm_pkg.sv
// shared types and constants for the column run segmenter
`timescale 1ns / 1ps
`default_nettype none

package crsm_pkg;

  localparam int ColW = 10;
  localparam int CountW = 7;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 10;
  localparam int MaxColumnsDefault = 1024;

  // output queue holds up to two results per column plus slack
  localparam int OutDepth = 4;
  localparam int OutPtrW = 2;
  localparam int OutCntW = 3;

  localparam logic [CountW-1:0] StartThresholdRst = 7'd1;
  localparam logic [ColW-1:0] WideWidthRst = 10'd12;
  localparam logic [ColW-1:0] MergeGapRst = 10'd6;
  localparam logic [ColW-1:0] MergeSpanRst = 10'd30;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStartThreshold = 2'd0,
    CfgWideWidth      = 2'd1,
    CfgMergeGap       = 2'd2,
    CfgMergeSpan      = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [CountW-1:0] column_count;
    logic              last_column;
  } col_in_t;

  typedef struct packed {
    logic [ColW-1:0] seg_start;
    logic [ColW-1:0] seg_end;
    logic            no_segment;
    logic            last_segment;
  } seg_out_t;

  // results written into the output queue in the same cycle
  typedef struct packed {
    logic [1:0] num;
    seg_out_t   first;
    seg_out_t   second;
  } seg_push_t;

endpackage

`default_nettype wire

### rtl/column_run_segmenter_merge.sv
// top level of the column run segmenter with narrow segment merging
//
// one column transfer on the input channel carries the set-pixel count of a
// column and a flag on the image's last column. a run opens when the count
// exceeds start_threshold and closes on a zero column; narrow segments merge
// into the pending one, superseded segments go out on the result channel.
// the last column flushes the pending segment with last_segment set, or an
// empty marker with no_segment set.
// state updates at the edge that takes a column, and its results land in a
// four-entry output queue, visible in the cycle after. up to two results come
// from one column, one result leaves per cycle while the receiver is ready.
// input ready stays high while the queue has room for two results, so the
// block takes new columns while earlier results still wait in the queue;
// once the queue fills, as when the receiver stalls, input ready drops.
// after reset the registers hold their reset values, no run or segment is
// pending and the queue is empty. the user must write registers only while idle; the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module column_run_segmenter_merge #(
  parameter int MAX_COLUMNS = crsm_pkg::MaxColumnsDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire crsm_pkg::col_in_t             in_data_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output crsm_pkg::seg_out_t                 out_data_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [crsm_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [crsm_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int PosLimitInt = (MAX_COLUMNS - 1 < 1023) ? (MAX_COLUMNS - 1) : 1023;
  localparam logic [crsm_pkg::ColW-1:0] PosLimit = crsm_pkg::ColW'(PosLimitInt);

  // configuration registers
  logic [crsm_pkg::CountW-1:0] start_thr_q;
  logic [crsm_pkg::ColW-1:0]   wide_width_q;
  logic [crsm_pkg::ColW-1:0]   merge_gap_q;
  logic [crsm_pkg::ColW-1:0]   merge_span_q;

  // scan state
  logic [crsm_pkg::ColW-1:0] col_pos_q, col_pos_d;
  logic                      run_open_q, run_open_d;
  logic [crsm_pkg::ColW-1:0] run_begin_q, run_begin_d;
  logic                      pend_valid_q, pend_valid_d;
  logic [crsm_pkg::ColW-1:0] pend_begin_q, pend_begin_d;
  logic [crsm_pkg::ColW-1:0] pend_finish_q, pend_finish_d;

  logic                      in_xfer;
  logic                      run_close;
  logic [crsm_pkg::ColW-1:0] seg_e;
  logic [crsm_pkg::ColW-1:0] seg_gap;
  logic                      do_merge;
  logic                      emit_old;
  logic                      mid_valid;
  logic [crsm_pkg::ColW-1:0] mid_begin;
  logic [crsm_pkg::ColW-1:0] mid_finish;
  crsm_pkg::seg_out_t        old_res;
  crsm_pkg::seg_out_t        last_res;
  crsm_pkg::seg_push_t       push;
  logic                      room2;
  logic [crsm_pkg::OutCntW-1:0] out_level;

  assign in_ready_o = room2;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q  <= crsm_pkg::StartThresholdRst;
      wide_width_q <= crsm_pkg::WideWidthRst;
      merge_gap_q  <= crsm_pkg::MergeGapRst;
      merge_span_q <= crsm_pkg::MergeSpanRst;
    end else if (cfg_we_i) begin
      unique case (crsm_pkg::cfg_reg_e'(cfg_idx_i))
        crsm_pkg::CfgStartThreshold: start_thr_q  <= cfg_wdata_i[crsm_pkg::CountW-1:0];
        crsm_pkg::CfgWideWidth:      wide_width_q <= cfg_wdata_i;
        crsm_pkg::CfgMergeGap:       merge_gap_q  <= cfg_wdata_i;
        crsm_pkg::CfgMergeSpan:      merge_span_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // segment closing on this column and its merge decision
  always_comb begin
    run_close = (in_data_i.column_count == '0) && run_open_q;
    seg_e     = (col_pos_q > run_begin_q) ? col_pos_q - crsm_pkg::ColW'(1) : run_begin_q;
    seg_gap   = (run_begin_q > pend_finish_q) ? run_begin_q - pend_finish_q : '0;
    do_merge  = pend_valid_q && ((seg_e - run_begin_q) <= wide_width_q)
                && (seg_gap <= merge_gap_q) && (seg_e >= pend_begin_q)
                && ((seg_e - pend_begin_q) < merge_span_q);
    emit_old  = run_close && !do_merge && pend_valid_q;

    mid_valid  = pend_valid_q;
    mid_begin  = pend_begin_q;
    mid_finish = pend_finish_q;
    if (run_close) begin
      mid_valid  = 1'b1;
      mid_finish = seg_e;
      if (!do_merge) begin
        mid_begin = run_begin_q;
      end
    end
  end

  always_comb begin
    old_res.seg_start    = pend_begin_q;
    old_res.seg_end      = pend_finish_q;
    old_res.no_segment   = 1'b0;
    old_res.last_segment = 1'b0;

    last_res.seg_start    = mid_valid ? mid_begin : '0;
    last_res.seg_end      = mid_valid ? mid_finish : '0;
    last_res.no_segment   = !mid_valid;
    last_res.last_segment = 1'b1;

    push.num    = 2'd0;
    push.first  = emit_old ? old_res : last_res;
    push.second = last_res;
    if (in_xfer) begin
      push.num = 2'(emit_old) + 2'(in_data_i.last_column);
    end
  end

  always_comb begin
    col_pos_d     = col_pos_q;
    run_open_d    = run_open_q;
    run_begin_d   = run_begin_q;
    pend_valid_d  = mid_valid;
    pend_begin_d  = mid_begin;
    pend_finish_d = mid_finish;

    if (in_data_i.column_count > start_thr_q) begin
      if (!run_open_q) begin
        run_open_d  = 1'b1;
        run_begin_d = col_pos_q;
      end
    end else if (run_close) begin
      run_open_d = 1'b0;
    end

    if (in_data_i.last_column) begin
      col_pos_d    = '0;
      run_open_d   = 1'b0;
      pend_valid_d = 1'b0;
    end else if (col_pos_q < PosLimit) begin
      col_pos_d = col_pos_q + crsm_pkg::ColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_pos_q     <= '0;
      run_open_q    <= 1'b0;
      run_begin_q   <= '0;
      pend_valid_q  <= 1'b0;
      pend_begin_q  <= '0;
      pend_finish_q <= '0;
    end else if (in_xfer) begin
      col_pos_q     <= col_pos_d;
      run_open_q    <= run_open_d;
      run_begin_q   <= run_begin_d;
      pend_valid_q  <= pend_valid_d;
      pend_begin_q  <= pend_begin_d;
      pend_finish_q <= pend_finish_d;
    end
  end

  crsm_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .room2_o    (room2),
    .level_o    (out_level),
    .rd_valid_o (out_valid_o),
    .rd_ready_i (out_ready_i),
    .rd_data_o  (out_data_o)
  );

  // queue never overflows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_level <= crsm_pkg::OutCntW'(crsm_pkg::OutDepth))
    else $error("output queue overflow");

  // a last column leaves no run and no pending segment behind
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && in_data_i.last_column |=> !run_open_q && !pend_valid_q && col_pos_q == '0)
    else $error("scan state not cleared after last column");

  // column position saturates
  assert property (@(posedge clk_i) disable iff (!rst_ni) col_pos_q <= PosLimit)
    else $error("column position beyond limit");

  // empty marker carries zero bounds and closes the image
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.no_segment |->
      out_data_o.last_segment && out_data_o.seg_start == '0 && out_data_o.seg_end == '0)
    else $error("malformed empty marker");

endmodule

`default_nettype wire

### rtl/crsm_out_fifo.sv
// output queue taking up to two results per cycle and handing out one while the reader is ready
`timescale 1ns / 1ps
`default_nettype none

module crsm_out_fifo (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire crsm_pkg::seg_push_t               push_i,
  output logic                                   room2_o,
  output logic [crsm_pkg::OutCntW-1:0]           level_o,
  output logic                                   rd_valid_o,
  input  wire logic                              rd_ready_i,
  output crsm_pkg::seg_out_t                     rd_data_o
);

  crsm_pkg::seg_out_t mem_q [crsm_pkg::OutDepth];

  logic [crsm_pkg::OutPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [crsm_pkg::OutPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [crsm_pkg::OutCntW-1:0] cnt_q, cnt_d;
  logic [crsm_pkg::OutPtrW-1:0] wr_ptr_nxt;
  logic                         pop;

  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign level_o    = cnt_q;
  assign room2_o    = (cnt_q <= crsm_pkg::OutCntW'(crsm_pkg::OutDepth - 2));
  assign wr_ptr_nxt = wr_ptr_q + crsm_pkg::OutPtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + crsm_pkg::OutPtrW'(push_i.num);
    rd_ptr_d = rd_ptr_q + crsm_pkg::OutPtrW'(pop);
    cnt_d    = cnt_q + crsm_pkg::OutCntW'(push_i.num) - crsm_pkg::OutCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.first;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.second;
    end
  end

endmodule

`default_nettype wire

### dv/tb.sv
// self-checking testbench for the column run segmenter with narrow segment merging
`timescale 1ns / 1ps

import crsm_pkg::*;

class segment_scoreboard;
  localparam int PosLimit = (MaxColumnsDefault - 1 < 1023) ? MaxColumnsDefault - 1 : 1023;

  logic [CountW-1:0] thr;
  logic [ColW-1:0]   wide;
  logic [ColW-1:0]   gap_max;
  logic [ColW-1:0]   span;

  logic [ColW-1:0] col_pos;
  logic            run_open;
  logic [ColW-1:0] run_begin;
  logic            pend_valid;
  logic [ColW-1:0] pend_begin;
  logic [ColW-1:0] pend_finish;

  seg_out_t    expected_q[$];
  int unsigned failures;

  function new();
    thr = StartThresholdRst;
    wide = WideWidthRst;
    gap_max = MergeGapRst;
    span = MergeSpanRst;
    col_pos = '0;
    run_open = 1'b0;
    run_begin = '0;
    pend_valid = 1'b0;
    pend_begin = '0;
    pend_finish = '0;
    failures = 0;
  endfunction

  function void set_reg(cfg_reg_e idx, logic [CfgDataW-1:0] val);
    case (idx)
      CfgStartThreshold: thr = val[CountW-1:0];
      CfgWideWidth:      wide = val;
      CfgMergeGap:       gap_max = val;
      CfgMergeSpan:      span = val;
      default: ;
    endcase
  endfunction

  // advance the column state by one accepted column and queue what it emits
  function void note_column(col_in_t col);
    logic [ColW-1:0] pos;
    logic [ColW-1:0] seg_s;
    logic [ColW-1:0] seg_e;
    int              gap;
    seg_out_t        res;
    pos = col_pos;
    if (col.column_count > thr) begin
      if (!run_open) begin
        run_open = 1'b1;
        run_begin = pos;
      end
    end else if (col.column_count == 0 && run_open) begin
      seg_s = run_begin;
      seg_e = (pos > run_begin) ? pos - 1'b1 : run_begin;
      run_open = 1'b0;
      gap = (seg_s > pend_finish) ? int'(seg_s) - int'(pend_finish) : 0;
      if (pend_valid && (seg_e - seg_s) <= wide && gap <= int'(gap_max) &&
          seg_e >= pend_begin && int'(seg_e) - int'(pend_begin) < int'(span)) begin
        pend_finish = seg_e;
      end else begin
        // superseded pending segment goes out
        if (pend_valid) begin
          res.seg_start = pend_begin;
          res.seg_end = pend_finish;
          res.no_segment = 1'b0;
          res.last_segment = 1'b0;
          expected_q.insert(expected_q.size(), res);
        end
        pend_valid = 1'b1;
        pend_begin = seg_s;
        pend_finish = seg_e;
      end
    end
    if (col.last_column) begin
      res.seg_start = pend_valid ? pend_begin : '0;
      res.seg_end = pend_valid ? pend_finish : '0;
      res.no_segment = !pend_valid;
      res.last_segment = 1'b1;
      expected_q.insert(expected_q.size(), res);
      col_pos = '0;
      run_open = 1'b0;
      pend_valid = 1'b0;
    end else if (pos < PosLimit) begin
      col_pos = pos + 1'b1;
    end
  endfunction

  function void check_segment(seg_out_t got);
    seg_out_t want;
    if (expected_q.size() == 0) begin
      failures++;
      if (failures <= 10)
        $display("unexpected segment: start %0d end %0d none %0b last %0b",
                 got.seg_start, got.seg_end, got.no_segment, got.last_segment);
      return;
    end
    want = expected_q.pop_front();
    if (got.seg_start !== want.seg_start || got.seg_end !== want.seg_end ||
        got.no_segment !== want.no_segment || got.last_segment !== want.last_segment) begin
      failures++;
      if (failures <= 10)
        $display({"segment mismatch: exp %0d..%0d none %0b last %0b, ",
                  "got %0d..%0d none %0b last %0b"},
                 want.seg_start, want.seg_end, want.no_segment, want.last_segment,
                 got.seg_start, got.seg_end, got.no_segment, got.last_segment);
    end
  endfunction
endclass

module tb;
  localparam int CycleLimit = 1000000;
  localparam int SqueezeCycles = 300;

  logic                clk;
  logic                rst_n;
  logic                col_valid;
  logic                col_ready;
  col_in_t             col_data;
  logic                seg_valid;
  logic                seg_ready;
  seg_out_t            seg_data;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  segment_scoreboard sb;
  int unsigned       cycle_cnt = 0;
  int unsigned       cur_thr = StartThresholdRst;
  int unsigned       cols_sent;
  bit                tx_idle_on = 1'b1;
  bit                rx_idle_on = 1'b1;
  bit                squeeze_req = 1'b0;

  column_run_segmenter_merge u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (col_valid),
    .in_ready_o  (col_ready),
    .in_data_i   (col_data),
    .out_valid_o (seg_valid),
    .out_ready_i (seg_ready),
    .out_data_o  (seg_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CycleLimit) begin
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && seg_valid && seg_ready) sb.check_segment(seg_data);
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned draw_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result receiver, with a long hold-off when asked
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    seg_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (squeeze_req) begin
        stall_left = SqueezeCycles;
        squeeze_req = 1'b0;
      end
      if (stall_left > 0) begin
        seg_ready <= 1'b0;
        stall_left--;
      end else begin
        seg_ready <= 1'b1;
        if (rx_idle_on) stall_left = draw_gap();
      end
    end
  end

  task automatic send_col(input logic [CountW-1:0] count, input logic last);
    int unsigned gap;
    gap = tx_idle_on ? draw_gap() : 0;
    if (gap > 0) begin
      @(negedge clk);
      col_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    col_valid <= 1'b1;
    col_data <= '{column_count: count, last_column: last};
    do @(posedge clk); while (!col_ready);
    sb.note_column(col_data);
    cols_sent++;
  endtask

  // runs mostly above threshold, closed by zero columns, some in-between counts
  function automatic logic [CountW-1:0] draw_count(input bit in_run);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < (in_run ? 20 : 55)) return '0;
    if (r < (in_run ? 30 : 65))
      return (cur_thr > 0) ? CountW'($urandom_range(1, cur_thr)) : '0;
    return (cur_thr < 64) ? CountW'($urandom_range(cur_thr + 1, 64))
                          : CountW'($urandom_range(0, 64));
  endfunction

  task automatic send_image(input int unsigned len);
    bit                in_run;
    logic [CountW-1:0] count;
    in_run = 1'b0;
    for (int unsigned i = 0; i < len; i++) begin
      count = draw_count(in_run);
      send_col(count, i == len - 1);
      if (count > cur_thr) in_run = 1'b1;
      else if (count == 0) in_run = 1'b0;
    end
  endtask

  // lets the block go idle: all results back plus its pipeline latency
  task automatic wait_drained();
    @(negedge clk);
    col_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_phase(input int unsigned t, w, g, s, n_cols, input bit tx_idle, rx_idle);
    cfg_reg_e            idx;
    logic [CfgDataW-1:0] val;
    int unsigned         r;
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      idx = cfg_reg_e'(i);
      case (idx)
        CfgStartThreshold: val = CfgDataW'(t);
        CfgWideWidth:      val = CfgDataW'(w);
        CfgMergeGap:       val = CfgDataW'(g);
        default:           val = CfgDataW'(s);
      endcase
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_idx <= idx;
      cfg_wdata <= val;
      sb.set_reg(idx, val);
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_thr = t;
    tx_idle_on = tx_idle;
    rx_idle_on = rx_idle;
    cols_sent = 0;
    while (cols_sent < n_cols) begin
      r = $urandom_range(0, 99);
      if (r < 5) send_image(1);
      else if (r < 90) send_image($urandom_range(2, 40));
      else send_image($urandom_range(41, 150));
    end
  endtask

  initial begin
    int unsigned dir_count[21] = '{0, 64, 2, 0, 1, 5, 0, 64, 64,
                                   3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 3, 0};
    bit          dir_last[21] = '{1, 0, 0, 0, 0, 0, 0, 0, 1,
                                  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1};
    sb = new();
    rst_n = 1'b0;
    col_valid = 1'b0;
    col_data = '0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: empty image, narrow first segment, merge, dropped open run,
    // superseded segment and flush on the same column
    for (int i = 0; i < 21; i++) send_col(CountW'(dir_count[i]), dir_last[i]);

    run_phase(0, 0, 0, 0, 80, 1'b1, 1'b1);
    run_phase(64, 1023, 1023, 1023, 40, 1'b1, 1'b1);
    run_phase(63, 5, 3, 10, 40, 1'b0, 1'b1);
    run_phase(1, 1023, 1023, 1023, 60, 1'b1, 1'b0);
    // receiver holds off while the sender keeps offering columns
    fork
      run_phase(1, 12, 6, 30, 100, 1'b0, 1'b0);
      begin
        wait (cols_sent == 10);
        squeeze_req = 1'b1;
      end
    join
    repeat (4) begin
      run_phase($urandom_range(0, 6), $urandom_range(0, 30), $urandom_range(0, 12),
                $urandom_range(0, 60), 30, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end

    // one image past the last column position: runs on the saturated column
    run_phase(2, 12, 6, 30, 0, 1'b1, 1'b1);
    begin
      bit                in_run;
      logic [CountW-1:0] count;
      in_run = 1'b0;
      for (int i = 0; i < 1023; i++) begin
        count = draw_count(in_run);
        send_col(count, 1'b0);
        if (count > cur_thr) in_run = 1'b1;
        else if (count == 0) in_run = 1'b0;
      end
      send_col('0, 1'b0);
      send_col(CountW'(64), 1'b0);
      send_col('0, 1'b0);
      send_col(CountW'(64), 1'b0);
      send_col('0, 1'b0);
      send_col('0, 1'b1);
    end

    wait_drained();
    repeat (8) @(negedge clk);
    sb.failures += sb.expected_q.size();
    if (sb.failures == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

### filelist.f
rtl/crsm_pkg.sv
rtl/crsm_out_fifo.sv
rtl/column_run_segmenter_merge.sv
dv/tb.sv
